/* sv/bwef_pkg.sv */
package bwef_pkg;

   localparam int DATA_W = 32;
   localparam int BUCKET_COUNT_DEF = 8;
   localparam int CSR_INDEX_W = 1;
   localparam logic [DATA_W-1:0] BUCKET_TICKS_RESET = 32'd1000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRACK_MAX    = 1'b0,
      CSR_BUCKET_TICKS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SHIFT,
      ST_FOLD,
      ST_SCAN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              clear;
      logic              shift;
      logic              fold;
      logic              track_max;
      logic [DATA_W-1:0] empty;
      logic [DATA_W-1:0] sample;
   } cell_ctl_type;

   function automatic logic [DATA_W-1:0] empty_value(input logic track_max);
      return track_max ? '0 : '1;
   endfunction

   function automatic logic [DATA_W-1:0] fold_value(input logic track_max,
                                                    input logic [DATA_W-1:0] a,
                                                    input logic [DATA_W-1:0] b);
      if (track_max) begin
         return (a > b) ? a : b;
      end
      return (a < b) ? a : b;
   endfunction

endpackage

/* sv/bucketed_windowed_extreme_filter.sv */
// Windowed min/max filter over timestamped samples.
// Request channel: req_valid/req_stall with req_sample_time and
// req_sample_value; one beat per sample, times nondecreasing.
// Response channel: rsp_valid/rsp_stall with rsp_filtered_value; exactly one
// beat per request beat, in order.
// Config: csr_write_enable/csr_index/csr_write_data, write only while idle.
// Index 0 selects max (1) or min (0) and restarts the window; index 1 sets
// the bucket width in ticks (0 acts as 1).
// Buckets live in a row of BUCKET_COUNT cells that shift toward cell 0.
// Per sample: the first after restart goes straight to the fold and the scan;
// later ones pass the bit-serial divide, the bucket shift by S (0..BUCKET_COUNT)
// positions, the fold, and the scan that rotates the row once past the
// accumulator. One sample is in work at a time; the next is taken as soon as
// the result is in the output register.
// A stalled result holds in the output register; the block then finishes
// the next sample and waits for the register to free.
// Reset: min mode, bucket width 1000, all buckets empty, window not started.
module bucketed_windowed_extreme_filter #(
   parameter int BUCKET_COUNT = bwef_pkg::BUCKET_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [bwef_pkg::DATA_W-1:0]      req_sample_time,
   input  logic [bwef_pkg::DATA_W-1:0]      req_sample_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bwef_pkg::DATA_W-1:0]      rsp_filtered_value,
   input  logic                             csr_write_enable,
   input  logic [bwef_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bwef_pkg::DATA_W-1:0]      csr_write_data
);

   localparam int W      = bwef_pkg::DATA_W;
   localparam int IDX_W  = $clog2(BUCKET_COUNT);
   localparam int CNT_W  = $clog2(BUCKET_COUNT + 1);

   bwef_pkg::state_type    state_ff, state_in;
   logic                   track_max_ff, track_max_in;
   logic [W-1:0]           ticks_ff, ticks_in;
   logic                   started_ff, started_in;
   logic [W-1:0]           ws_ff, ws_in;
   logic [W-1:0]           t_ff, t_in;
   logic [W-1:0]           v_ff, v_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [W-1:0]           lead_ff, lead_in;
   logic [W-1:0]           acc_ff, acc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]           rsp_value_ff, rsp_value_in;

   bwef_pkg::cell_ctl_type ctl;
   logic [W-1:0]           cell_value [BUCKET_COUNT];
   logic [W-1:0]           tail_in;
   logic                   rotate;

   logic                   accept;
   logic [W-1:0]           width_eff;
   logic [W-1:0]           lead_span;
   logic [W-1:0]           diff;
   logic                   div_start;
   logic                   div_done;
   logic [W-1:0]           div_quot;
   logic [W-1:0]           div_rem;
   logic                   out_free;

   assign accept    = req_valid && !req_stall;
   assign width_eff = (ticks_ff == '0) ? W'(1) : ticks_ff;
   assign lead_span = width_eff * W'(BUCKET_COUNT - 1);
   assign diff      = (req_sample_time > ws_ff) ? (req_sample_time - ws_ff) : '0;
   assign div_start = accept && started_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   bwef_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (diff),
      .divisor   (width_eff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign tail_in = rotate ? cell_value[0] : ctl.empty;

   for (genvar i = 0; i < BUCKET_COUNT; i++) begin : g_cell
      logic [W-1:0] nbr;
      if (i == BUCKET_COUNT - 1) begin : g_tail
         assign nbr = tail_in;
      end else begin : g_body
         assign nbr = cell_value[i+1];
      end
      bwef_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .hit        (idx_ff == IDX_W'(i)),
         .nbr_value  (nbr),
         .cell_value (cell_value[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      track_max_in = track_max_ff;
      ticks_in     = ticks_ff;
      started_in   = started_ff;
      ws_in        = ws_ff;
      t_in         = t_ff;
      v_in         = v_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      lead_in      = lead_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rotate       = 1'b0;
      req_stall    = 1'b1;

      ctl.clear     = 1'b0;
      ctl.shift     = 1'b0;
      ctl.fold      = 1'b0;
      ctl.track_max = track_max_ff;
      ctl.empty     = bwef_pkg::empty_value(track_max_ff);
      ctl.sample    = v_ff;

      if (csr_write_enable) begin
         case (bwef_pkg::csr_index_type'(csr_index))
            bwef_pkg::CSR_TRACK_MAX: begin
               track_max_in  = csr_write_data[0];
               started_in    = 1'b0;
               ws_in         = '0;
               ctl.clear     = 1'b1;
               ctl.track_max = csr_write_data[0];
               ctl.empty     = bwef_pkg::empty_value(csr_write_data[0]);
            end
            bwef_pkg::CSR_BUCKET_TICKS: begin
               ticks_in = csr_write_data;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         bwef_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               t_in    = req_sample_time;
               v_in    = req_sample_value;
               lead_in = lead_span;
               if (started_ff) begin
                  state_in = bwef_pkg::ST_DIV;
               end else begin
                  started_in = 1'b1;
                  ws_in      = req_sample_time;
                  idx_in     = '0;
                  state_in   = bwef_pkg::ST_FOLD;
               end
            end
         end
         bwef_pkg::ST_DIV: begin
            if (div_done) begin
               if (div_quot >= W'(BUCKET_COUNT)) begin
                  idx_in = IDX_W'(BUCKET_COUNT - 1);
                  ws_in  = t_ff - div_rem - lead_ff;
                  if (div_quot >= W'(2 * BUCKET_COUNT - 1)) begin
                     cnt_in = CNT_W'(BUCKET_COUNT);
                  end else begin
                     cnt_in = CNT_W'(div_quot - W'(BUCKET_COUNT - 1));
                  end
                  state_in = bwef_pkg::ST_SHIFT;
               end else begin
                  idx_in   = div_quot[IDX_W-1:0];
                  state_in = bwef_pkg::ST_FOLD;
               end
            end
         end
         bwef_pkg::ST_SHIFT: begin
            ctl.shift = 1'b1;
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = bwef_pkg::ST_FOLD;
            end
         end
         bwef_pkg::ST_FOLD: begin
            ctl.fold = 1'b1;
            acc_in   = bwef_pkg::empty_value(track_max_ff);
            cnt_in   = CNT_W'(BUCKET_COUNT);
            state_in = bwef_pkg::ST_SCAN;
         end
         bwef_pkg::ST_SCAN: begin
            ctl.shift = 1'b1;
            rotate    = 1'b1;
            acc_in    = bwef_pkg::fold_value(track_max_ff, acc_ff, cell_value[0]);
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = bwef_pkg::ST_OUT;
            end
         end
         bwef_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = acc_ff;
               state_in     = bwef_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bwef_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bwef_pkg::ST_IDLE;
         track_max_ff <= 1'b0;
         ticks_ff     <= bwef_pkg::BUCKET_TICKS_RESET;
         started_ff   <= 1'b0;
         ws_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         track_max_ff <= track_max_in;
         ticks_ff     <= ticks_in;
         started_ff   <= started_in;
         ws_ff        <= ws_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff         <= t_in;
      v_ff         <= v_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      lead_ff      <= lead_in;
      acc_ff       <= acc_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;

endmodule

/* sv/bwef_cell.sv */
module bwef_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  bwef_pkg::cell_ctl_type      ctl,
   input  logic                        hit,
   input  logic [bwef_pkg::DATA_W-1:0] nbr_value,
   output logic [bwef_pkg::DATA_W-1:0] cell_value
);

   logic [bwef_pkg::DATA_W-1:0] value_ff;
   logic [bwef_pkg::DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.clear) begin
         value_in = ctl.empty;
      end else if (ctl.shift) begin
         value_in = nbr_value;
      end else if (ctl.fold && hit) begin
         value_in = bwef_pkg::fold_value(ctl.track_max, value_ff, ctl.sample);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= bwef_pkg::empty_value(1'b0);
      end else begin
         value_ff <= value_in;
      end
   end

   assign cell_value = value_ff;

endmodule

/* sv/bwef_div.sv */
module bwef_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bwef_pkg::DATA_W-1:0] dividend,
   input  logic [bwef_pkg::DATA_W-1:0] divisor,
   output logic                        done,
   output logic [bwef_pkg::DATA_W-1:0] quotient,
   output logic [bwef_pkg::DATA_W-1:0] remainder
);

   localparam int CNT_W = $clog2(bwef_pkg::DATA_W);

   logic                        busy_ff;
   logic                        done_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [bwef_pkg::DATA_W-1:0] dvd_ff;
   logic [bwef_pkg::DATA_W-1:0] dvs_ff;
   logic [bwef_pkg::DATA_W-1:0] rem_ff;
   logic [bwef_pkg::DATA_W:0]   trial;

   assign trial = {rem_ff, dvd_ff[bwef_pkg::DATA_W-1]} - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            dvd_ff  <= dividend;
            dvs_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            if (trial[bwef_pkg::DATA_W]) begin
               rem_ff <= {rem_ff[bwef_pkg::DATA_W-2:0], dvd_ff[bwef_pkg::DATA_W-1]};
            end else begin
               rem_ff <= trial[bwef_pkg::DATA_W-1:0];
            end
            dvd_ff <= {dvd_ff[bwef_pkg::DATA_W-2:0], ~trial[bwef_pkg::DATA_W]};
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(bwef_pkg::DATA_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

/* sim/tb_bucketed_windowed_extreme_filter.sv */
`timescale 1ns / 1ps

module tb_bucketed_windowed_extreme_filter;

   localparam int DATA_W = bwef_pkg::DATA_W;
   localparam int CSR_INDEX_W = bwef_pkg::CSR_INDEX_W;
   localparam int NB = bwef_pkg::BUCKET_COUNT_DEF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD = 400;
   localparam int PHASE_ITEMS = 58;
   localparam int NUM_PHASES = 10;

   typedef struct packed {
      logic [DATA_W-1:0] stamp;
      logic [DATA_W-1:0] value;
   } sample_beat_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [DATA_W-1:0]      req_sample_time = '0;
   logic [DATA_W-1:0]      req_sample_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [DATA_W-1:0]      rsp_filtered_value;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]      csr_write_data = '0;

   bucketed_windowed_extreme_filter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_time    (req_sample_time),
      .req_sample_value   (req_sample_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_value (rsp_filtered_value),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   // window tracker copy
   logic              mode_max;
   logic [DATA_W-1:0] tick_width;
   logic [DATA_W-1:0] win_buckets [NB];
   logic [DATA_W-1:0] win_start;
   logic              win_open;

   sample_beat_type   pending_samples [$];
   logic [DATA_W-1:0] expected_extremes [$];

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   int   fail_count = 0;
   int   idle_cycles = 0;
   int   send_gap = 0;
   int   recv_gap = 0;
   int   send_idle_pct = 20;
   int   recv_idle_pct = 20;
   logic quiet_tail = 1'b0;
   logic hold_armed = 1'b0;
   int   hold_count = 0;

   function automatic logic [DATA_W-1:0] idle_level();
      return mode_max ? '0 : '1;
   endfunction

   function automatic logic [DATA_W-1:0] pick_extreme(input logic [DATA_W-1:0] a,
                                                      input logic [DATA_W-1:0] b);
      if (mode_max) begin
         return (a > b) ? a : b;
      end
      return (a < b) ? a : b;
   endfunction

   task automatic restart_window();
      for (int i = 0; i < NB; i++) begin
         win_buckets[i] = idle_level();
      end
      win_start = '0;
      win_open = 1'b0;
   endtask

   // updates the tracker with one sample and returns the windowed extreme
   function automatic logic [DATA_W-1:0] fold_sample(input logic [DATA_W-1:0] t,
                                                     input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] w;
      logic [DATA_W-1:0] acc;
      logic [63:0]       idx;
      logic [63:0]       shift;
      int                i;
      w = (tick_width == '0) ? 32'd1 : tick_width;
      if (!win_open) begin
         win_open = 1'b1;
         win_start = t;
         win_buckets[0] = v;
         return v;
      end
      idx = (t > win_start) ? (64'(t - win_start) / 64'(w)) : 64'd0;
      if (idx >= NB) begin
         shift = idx - NB + 1;
         win_start = win_start + 32'(shift * 64'(w));
         for (i = 0; i < NB; i++) begin
            if (64'(i) + shift < NB) begin
               win_buckets[i] = win_buckets[i + int'(shift)];
            end else begin
               win_buckets[i] = idle_level();
            end
         end
         idx = NB - 1;
      end
      win_buckets[idx] = pick_extreme(win_buckets[idx], v);
      acc = idle_level();
      for (i = 0; i < NB; i++) begin
         acc = pick_extreme(acc, win_buckets[i]);
      end
      return acc;
   endfunction

   task automatic queue_sample(input logic [DATA_W-1:0] t, input logic [DATA_W-1:0] v);
      sample_beat_type beat;
      beat.stamp = t;
      beat.value = v;
      pending_samples.insert(pending_samples.size(), beat);
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_valid || expected_extremes.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input bwef_pkg::csr_index_type idx,
                            input logic [DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == bwef_pkg::CSR_TRACK_MAX) begin
         mode_max = data[0];
         restart_window();
      end else begin
         tick_width = data;
      end
      @(posedge clock);
   endtask

   task automatic set_mode(input logic want_max);
      logic [DATA_W-1:0] data;
      data = $urandom;
      data[0] = want_max;
      write_csr(bwef_pkg::CSR_TRACK_MAX, data);
   endtask

   initial begin
      forever #2 clock = ~clock;
   end

   // request driver
   always @(negedge clock) begin : drive_req
      sample_beat_type beat;
      if (!reset && !(req_valid && req_fire)) begin
         if (req_valid) begin
            // held beat, keep payload
         end else if (send_gap > 0) begin
            send_gap = send_gap - 1;
         end else if (!quiet_tail && $urandom_range(99) < send_idle_pct) begin
            send_gap = $urandom_range(6, 1) - 1;
         end else if (pending_samples.size() != 0) begin
            beat = pending_samples.pop_front();
            req_valid <= 1'b1;
            req_sample_time <= beat.stamp;
            req_sample_value <= beat.value;
         end
      end else if (!reset) begin
         // beat taken at the last edge
         if (send_gap == 0 && !(!quiet_tail && $urandom_range(99) < send_idle_pct)
             && pending_samples.size() != 0) begin
            beat = pending_samples.pop_front();
            req_sample_time <= beat.stamp;
            req_sample_value <= beat.value;
         end else begin
            if (!quiet_tail && send_gap == 0 && pending_samples.size() != 0) begin
               send_gap = $urandom_range(6, 1) - 1;
            end
            req_valid <= 1'b0;
         end
      end
   end

   // response stall
   always @(negedge clock) begin : drive_rsp
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_armed && hold_count < LONG_HOLD) begin
         hold_count = hold_count + 1;
         rsp_stall <= 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap = recv_gap - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(99) < recv_idle_pct) begin
         recv_gap = $urandom_range(6, 1) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor and checker
   always @(posedge clock) begin : watch
      logic [DATA_W-1:0] want;
      req_fire = !reset && req_valid && (req_stall === 1'b0);
      rsp_fire = !reset && (rsp_valid === 1'b1) && (rsp_stall === 1'b0);
      if (rsp_fire) begin
         if (expected_extremes.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h", $time,
                     rsp_filtered_value);
            fail_count = fail_count + 1;
         end else begin
            want = expected_extremes.pop_front();
            if (rsp_filtered_value !== want) begin
               $display("%0t: filtered_value mismatch, expected %h, actual %h", $time,
                        want, rsp_filtered_value);
               fail_count = fail_count + 1;
            end
         end
      end
      if (req_fire) begin
         expected_extremes.insert(expected_extremes.size(),
                                  fold_sample(req_sample_time, req_sample_value));
      end
      if (req_fire || rsp_fire) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL bucketed_windowed_extreme_filter");
         $finish;
      end
   end

   initial begin : stimulus
      logic [DATA_W-1:0] now_t;
      logic [DATA_W-1:0] w;
      logic [DATA_W-1:0] v;
      logic [63:0]       step;
      logic              next_max;
      int                pick;

      mode_max = 1'b0;
      tick_width = bwef_pkg::BUCKET_TICKS_RESET;
      restart_window();
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: min mode, width 1000
      queue_sample(32'd100, 32'd500);
      queue_sample(32'd100, 32'd700);
      queue_sample(32'd1099, 32'd300);
      queue_sample(32'd1100, 32'hFFFF_FFFF);
      queue_sample(32'd8099, 32'd0);
      queue_sample(32'd8100, 32'd50);
      queue_sample(32'd9999, 32'd60);
      queue_sample(32'd50, 32'd10);
      queue_sample(32'hFFFF_FFFF, 32'd20);
      queue_sample(32'hFFFF_FFFF, 32'd0);
      wait_drained();

      // width change keeps the window
      write_csr(bwef_pkg::CSR_BUCKET_TICKS, 32'd0);
      queue_sample(32'hFFFF_FFFF, 32'd7);
      queue_sample(32'd3, 32'hFFFF_FFFE);
      wait_drained();

      set_mode(1'b1);
      queue_sample(32'd0, 32'd0);
      queue_sample(32'd0, 32'd5);
      queue_sample(32'd7, 32'hFFFF_FFFF);
      queue_sample(32'd9, 32'd3);
      queue_sample(32'd20, 32'd1);
      queue_sample(32'd20, 32'd0);
      wait_drained();

      write_csr(bwef_pkg::CSR_BUCKET_TICKS, 32'hFFFF_FFFF);
      queue_sample(32'hFFFF_FFFE, 32'd9);
      queue_sample(32'hFFFF_FFFF, 32'd8);
      queue_sample(32'h0000_0001, 32'hFFFF_FFFF);
      wait_drained();

      set_mode(1'b0);
      write_csr(bwef_pkg::CSR_BUCKET_TICKS, 32'd1);
      queue_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_sample(32'hFFFF_FFFF, 32'd0);
      queue_sample(32'd0, 32'd4);
      wait_drained();

      now_t = $urandom;
      next_max = 1'b0;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph % 3 != 2) begin
            next_max = (ph % 2 == 0) ? ~next_max : 1'($urandom_range(1));
            set_mode(next_max);
            now_t = $urandom;
         end
         case ($urandom_range(5))
            0: w = 32'd1;
            1: w = 32'd0;
            2: w = 32'hFFFF_FFFF;
            3: w = $urandom_range(64, 1);
            4: w = $urandom_range(100000, 1);
            default: w = $urandom;
         endcase
         write_csr(bwef_pkg::CSR_BUCKET_TICKS, w);
         if (w == '0) begin
            w = 32'd1;
         end
         case ($urandom_range(2))
            0: send_idle_pct = 0;
            1: send_idle_pct = 25;
            default: send_idle_pct = 75;
         endcase
         case ($urandom_range(2))
            0: recv_idle_pct = 0;
            1: recv_idle_pct = 25;
            default: recv_idle_pct = 75;
         endcase
         if (ph == 3) begin
            hold_armed = 1'b1;
         end
         if (ph == NUM_PHASES - 1) begin
            quiet_tail = 1'b1;
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
               step = 64'd0;
            end else if (pick < 65) begin
               step = 64'($urandom_range(w, 0));
            end else if (pick < 82) begin
               step = 64'(w) * 64'($urandom_range(NB + 2, 1));
            end else if (pick < 94) begin
               step = 64'($urandom);
            end else begin
               // out of order stamp
               step = -64'($urandom_range(w, 0));
            end
            now_t = now_t + step[DATA_W-1:0];
            pick = $urandom_range(99);
            if (pick < 10) begin
               v = $urandom_range(1) ? '1 : '0;
            end else if (pick < 30) begin
               v = $urandom_range(255);
            end else begin
               v = $urandom;
            end
            queue_sample(now_t, v);
         end
         wait_drained();
      end

      repeat (60) @(posedge clock);
      if (fail_count == 0 && expected_extremes.size() == 0) begin
         $display("PASS bucketed_windowed_extreme_filter");
      end else begin
         $display("FAIL bucketed_windowed_extreme_filter");
      end
      $finish;
   end

endmodule
